// ----- sv/sffa_pkg.sv -----
package sffa_pkg;

   localparam int MEM_UNITS_DEF = 64;
   localparam logic [7:0] BLANK_BYTE = 8'h20;

   localparam logic [2:0] CMD_ALLOC     = 3'd0;
   localparam logic [2:0] CMD_WRITE     = 3'd1;
   localparam logic [2:0] CMD_READ      = 3'd2;
   localparam logic [2:0] CMD_FREE_SEG  = 3'd3;
   localparam logic [2:0] CMD_FREE_PROC = 3'd4;
   localparam logic [2:0] CMD_FREE_ALL  = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_SPACE  = 3'd1;
   localparam logic [2:0] ST_EXISTS    = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_ADDR_ERR  = 3'd4;
   localparam logic [2:0] ST_NOTHING   = 3'd5;
   localparam logic [2:0] ST_INVALID   = 3'd6;

   typedef enum logic [2:0] {
      OP_ALLOC,
      OP_WRITE,
      OP_READ,
      OP_FREE_SEG,
      OP_FREE_PROC,
      OP_FREE_ALL,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] process_id;
      logic [7:0] segment_number;
      logic [6:0] length;
      logic [5:0] offset;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] base_address;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic       proc_zero;
      logic       len_zero;
      logic       len_over;
      logic [7:0] process_id;
      logic [7:0] segment_number;
      logic [6:0] length;
      logic [5:0] offset;
      logic [7:0] write_data;
   } task_type;

   typedef struct packed {
      logic [7:0] process_id;
      logic [7:0] segment_number;
      logic [6:0] limit;
   } ent_type;

endpackage

// ----- sv/sffa_front.sv -----
module sffa_front #(
   parameter int MEM_UNITS = sffa_pkg::MEM_UNITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sffa_pkg::req_type  req_data,
   input  logic               hold,
   output logic               task_valid,
   input  logic               task_pop,
   output sffa_pkg::task_type task_data
);

   sffa_pkg::task_type cls;
   sffa_pkg::task_type q_ff [2];
   logic               wp_ff, wp_in;
   logic               rp_ff, rp_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               push, pop;

   always_comb begin
      cls.process_id     = req_data.process_id;
      cls.segment_number = req_data.segment_number;
      cls.length         = req_data.length;
      cls.offset         = req_data.offset;
      cls.write_data     = req_data.write_data;
      cls.proc_zero      = (req_data.process_id == 8'd0);
      cls.len_zero       = (req_data.length == 7'd0);
      cls.len_over       = (32'(req_data.length) > 32'(MEM_UNITS));
      unique case (req_data.command)
         sffa_pkg::CMD_ALLOC:     cls.op = sffa_pkg::OP_ALLOC;
         sffa_pkg::CMD_WRITE:     cls.op = sffa_pkg::OP_WRITE;
         sffa_pkg::CMD_READ:      cls.op = sffa_pkg::OP_READ;
         sffa_pkg::CMD_FREE_SEG:  cls.op = sffa_pkg::OP_FREE_SEG;
         sffa_pkg::CMD_FREE_PROC: cls.op = sffa_pkg::OP_FREE_PROC;
         sffa_pkg::CMD_FREE_ALL:  cls.op = sffa_pkg::OP_FREE_ALL;
         default:                 cls.op = sffa_pkg::OP_BAD;
      endcase
   end

   assign req_stall  = hold || (cnt_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign task_valid = (cnt_ff != 2'd0);
   assign pop        = task_pop && task_valid;
   assign task_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- sv/sffa_engine.sv -----
module sffa_engine #(
   parameter int MEM_UNITS = sffa_pkg::MEM_UNITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               task_valid,
   output logic               task_pop,
   input  sffa_pkg::task_type task_data,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sffa_pkg::rsp_type  rsp_data
);

   localparam int AW = $clog2(MEM_UNITS);
   localparam int CW = $clog2(MEM_UNITS + 1);
   localparam int LW = ((AW > 7) ? AW : 7) + 1;
   localparam int BW = (AW > 6) ? AW : 6;

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b000_0000_0001,
      S_IDLE   = 11'b000_0000_0010,
      S_FIND   = 11'b000_0000_0100,
      S_FIT    = 11'b000_0000_1000,
      S_MARK   = 11'b000_0001_0000,
      S_CHECK  = 11'b000_0010_0000,
      S_ACCESS = 11'b000_0100_0000,
      S_REL    = 11'b000_1000_0000,
      S_PSCAN  = 11'b001_0000_0000,
      S_ALL    = 11'b010_0000_0000,
      S_DONE   = 11'b100_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      e_ff, e_in;
   logic [AW-1:0]      k_ff, k_in;
   logic [AW-1:0]      start_ff, start_in;
   logic [CW-1:0]      run_ff, run_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [6:0]         lim_ff, lim_in;
   logic               hit_ff, hit_in;
   sffa_pkg::task_type tk_ff, tk_in;
   sffa_pkg::rsp_type  res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sffa_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic               used_mem [MEM_UNITS];
   sffa_pkg::ent_type  ent_mem [MEM_UNITS];
   logic [7:0]         data_mem [MEM_UNITS];
   logic               used_q;
   sffa_pkg::ent_type  ent_q;
   logic [7:0]         data_q;

   logic               u_we, u_wd;
   logic [AW-1:0]      u_wa;
   logic               e_we;
   logic [AW-1:0]      e_wa;
   sffa_pkg::ent_type  e_wd;
   logic               d_we;
   logic [AW-1:0]      d_wa;
   logic [7:0]         d_wd;

   logic               last;
   logic               match;
   logic [AW-1:0]      unit;
   logic [LW-1:0]      dsum;
   logic [AW-1:0]      d_ra;
   logic [BW-1:0]      e_ext;
   logic [5:0]         base6;
   logic [CW-1:0]      run_nx;
   logic               rel_end;
   logic               mark_end;
   logic               addr_bad;
   logic               rsp_load;

   always_comb begin
      last     = (idx_ff == AW'(MEM_UNITS - 1));
      match    = (ent_q.process_id != 8'd0) && (ent_q.process_id == tk_ff.process_id)
                 && (ent_q.segment_number == tk_ff.segment_number);
      unit     = e_ff + k_ff;
      dsum     = LW'(e_ff) + LW'(tk_ff.offset);
      d_ra     = dsum[AW-1:0];
      e_ext    = BW'(e_ff);
      base6    = e_ext[5:0];
      run_nx   = run_ff + 1'b1;
      rel_end  = ((LW'(k_ff) + 1'b1) == LW'(lim_ff)) || (unit == AW'(MEM_UNITS - 1));
      mark_end = ((CW'(k_ff) + 1'b1) == CW'(tk_ff.length));
      addr_bad = (LW'(tk_ff.offset) >= LW'(lim_ff)) || (dsum >= LW'(MEM_UNITS));
      rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      e_in         = e_ff;
      k_in         = k_ff;
      start_in     = start_ff;
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      hit_in       = hit_ff;
      tk_in        = tk_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      task_pop     = 1'b0;
      u_we         = 1'b0;
      u_wa         = idx_ff;
      u_wd         = 1'b0;
      e_we         = 1'b0;
      e_wa         = idx_ff;
      e_wd         = '0;
      d_we         = 1'b0;
      d_wa         = unit;
      d_wd         = sffa_pkg::BLANK_BYTE;

      unique case (state_ff)
         S_CLEAR: begin
            u_we = 1'b1;
            e_we = 1'b1;
            if (last) begin
               cnt_in   = '0;
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (task_valid) begin
               task_pop         = 1'b1;
               tk_in            = task_data;
               idx_in           = '0;
               hit_in           = 1'b0;
               res_in.status    = sffa_pkg::ST_INVALID;
               res_in.base_address = 6'd0;
               res_in.read_data = 8'd0;
               state_in         = S_DONE;
               unique case (task_data.op)
                  sffa_pkg::OP_ALLOC: begin
                     if (!task_data.proc_zero && !task_data.len_zero) begin
                        state_in = S_FIND;
                     end
                  end
                  sffa_pkg::OP_WRITE, sffa_pkg::OP_READ: begin
                     if (!task_data.proc_zero) begin
                        state_in = S_FIND;
                     end
                  end
                  sffa_pkg::OP_FREE_SEG: begin
                     if (cnt_ff == '0) begin
                        res_in.status = sffa_pkg::ST_NOTHING;
                     end else if (!task_data.proc_zero) begin
                        state_in = S_FIND;
                     end
                  end
                  sffa_pkg::OP_FREE_PROC: begin
                     if (cnt_ff == '0) begin
                        res_in.status = sffa_pkg::ST_NOTHING;
                     end else if (!task_data.proc_zero) begin
                        state_in = S_PSCAN;
                     end
                  end
                  sffa_pkg::OP_FREE_ALL: begin
                     if (cnt_ff == '0) begin
                        res_in.status = sffa_pkg::ST_NOTHING;
                     end else begin
                        state_in = S_ALL;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_FIND: begin
            if (match) begin
               e_in   = idx_ff;
               lim_in = ent_q.limit;
               k_in   = '0;
               case (tk_ff.op)
                  sffa_pkg::OP_ALLOC: begin
                     res_in.status = sffa_pkg::ST_EXISTS;
                     state_in      = S_DONE;
                  end
                  sffa_pkg::OP_FREE_SEG: state_in = S_REL;
                  default:               state_in = S_CHECK;
               endcase
            end else if (last) begin
               if (tk_ff.op == sffa_pkg::OP_ALLOC) begin
                  if (tk_ff.len_over) begin
                     res_in.status = sffa_pkg::ST_NO_SPACE;
                     state_in      = S_DONE;
                  end else begin
                     idx_in   = '0;
                     run_in   = '0;
                     start_in = '0;
                     state_in = S_FIT;
                  end
               end else begin
                  res_in.status = sffa_pkg::ST_NOT_FOUND;
                  state_in      = S_DONE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FIT: begin
            if (!used_q && (run_nx == CW'(tk_ff.length))) begin
               e_in     = start_ff;
               k_in     = '0;
               state_in = S_MARK;
            end else begin
               if (used_q) begin
                  run_in   = '0;
                  start_in = idx_ff + 1'b1;
               end else begin
                  run_in = run_nx;
               end
               if (last) begin
                  res_in.status = sffa_pkg::ST_NO_SPACE;
                  state_in      = S_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_MARK: begin
            u_we = 1'b1;
            u_wa = unit;
            u_wd = 1'b1;
            if (mark_end) begin
               e_we                = 1'b1;
               e_wa                = e_ff;
               e_wd.process_id     = tk_ff.process_id;
               e_wd.segment_number = tk_ff.segment_number;
               e_wd.limit          = tk_ff.length;
               cnt_in              = cnt_ff + CW'(tk_ff.length);
               res_in.status       = sffa_pkg::ST_OK;
               res_in.base_address = base6;
               state_in            = S_DONE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_CHECK: begin
            res_in.base_address = base6;
            if (addr_bad) begin
               res_in.status = sffa_pkg::ST_ADDR_ERR;
               state_in      = S_DONE;
            end else if (tk_ff.op == sffa_pkg::OP_WRITE) begin
               d_we          = 1'b1;
               d_wa          = d_ra;
               d_wd          = tk_ff.write_data;
               res_in.status = sffa_pkg::ST_OK;
               state_in      = S_DONE;
            end else begin
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            res_in.status    = sffa_pkg::ST_OK;
            res_in.read_data = data_q;
            state_in         = S_DONE;
         end
         S_REL: begin
            u_we = 1'b1;
            u_wa = unit;
            d_we = 1'b1;
            if (rel_end) begin
               e_we   = 1'b1;
               e_wa   = e_ff;
               cnt_in = cnt_ff - CW'(lim_ff);
               if (tk_ff.op == sffa_pkg::OP_FREE_SEG) begin
                  res_in.status       = sffa_pkg::ST_OK;
                  res_in.base_address = base6;
                  state_in            = S_DONE;
               end else if (last) begin
                  res_in.status = sffa_pkg::ST_OK;
                  state_in      = S_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_PSCAN;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_PSCAN: begin
            if (ent_q.process_id == tk_ff.process_id) begin
               hit_in   = 1'b1;
               e_in     = idx_ff;
               lim_in   = ent_q.limit;
               k_in     = '0;
               state_in = S_REL;
            end else if (last) begin
               res_in.status = hit_ff ? sffa_pkg::ST_OK : sffa_pkg::ST_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_ALL: begin
            u_we = 1'b1;
            e_we = 1'b1;
            d_we = 1'b1;
            d_wa = idx_ff;
            if (last) begin
               cnt_in        = '0;
               res_in.status = sffa_pkg::ST_OK;
               state_in      = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (u_we) begin
         used_mem[u_wa] <= u_wd;
      end
      if (e_we) begin
         ent_mem[e_wa] <= e_wd;
      end
      if (d_we) begin
         data_mem[d_wa] <= d_wd;
      end
      used_q <= used_mem[idx_in];
      ent_q  <= ent_mem[idx_in];
      data_q <= data_mem[d_ra];
   end

   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      k_ff        <= k_in;
      start_ff    <= start_in;
      run_ff      <= run_in;
      lim_ff      <= lim_in;
      tk_ff       <= tk_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign clearing  = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MEM_UNITS))
      else $error("used count exceeds memory size");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      task_pop |-> (state_ff == S_IDLE))
      else $error("task taken outside idle");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_nothing: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (res_ff.status == sffa_pkg::ST_NOTHING)) |-> (cnt_ff == '0))
      else $error("nothing-allocated status with units in use");
`endif

endmodule

// ----- sv/segment_first_fit_allocator.sv -----
// First-fit segment allocator: one response transaction per request transaction.
// After reset the block sweeps every entry of its tables and holds req_stall
// high. A request then walks the tables, one unit per cycle through a single
// read port per table: a lookup walks up to MEM_UNITS entries, allocate adds a
// fit scan of up to MEM_UNITS units plus its length of units to mark, free
// process walks all entries plus each freed length, and free all sweeps all
// MEM_UNITS units. A two-deep request queue and a response register let each
// side stall independently.
module segment_first_fit_allocator #(
   parameter int MEM_UNITS = sffa_pkg::MEM_UNITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sffa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sffa_pkg::rsp_type rsp_data
);

   logic               task_valid;
   logic               task_pop;
   sffa_pkg::task_type task_data;
   logic               clearing;

   sffa_front #(
      .MEM_UNITS(MEM_UNITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .hold       (clearing),
      .task_valid (task_valid),
      .task_pop   (task_pop),
      .task_data  (task_data)
   );

   sffa_engine #(
      .MEM_UNITS(MEM_UNITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .task_valid (task_valid),
      .task_pop   (task_pop),
      .task_data  (task_data),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   localparam int UNITS = sffa_pkg::MEM_UNITS_DEF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sffa_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sffa_pkg::rsp_type rsp_data;

   segment_first_fit_allocator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   logic       map_used [UNITS];
   logic [7:0] map_byte [UNITS];
   logic       map_written [UNITS];
   logic [7:0] tbl_proc [UNITS];
   logic [7:0] tbl_seg [UNITS];
   logic [6:0] tbl_lim [UNITS];

   sffa_pkg::rsp_type expected_rsp[$];
   int                fail_count = 0;
   bit                send_done = 1'b0;
   int                rsp_wait = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("FAILURE");
      $finish;
   end

   function automatic int lookup_entry(logic [7:0] p, logic [7:0] s);
      for (int i = 0; i < UNITS; i++) begin
         if (tbl_proc[i] != 0 && tbl_proc[i] == p && tbl_seg[i] == s) return i;
      end
      return -1;
   endfunction

   function automatic bit any_in_use();
      for (int i = 0; i < UNITS; i++) begin
         if (map_used[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void release_segment(int e);
      for (int k = e; k < e + tbl_lim[e] && k < UNITS; k++) begin
         map_used[k] = 1'b0;
         map_byte[k] = sffa_pkg::BLANK_BYTE;
         map_written[k] = 1'b1;
      end
      tbl_proc[e] = '0;
      tbl_seg[e] = '0;
      tbl_lim[e] = '0;
   endfunction

   function automatic int fit_scan(int len);
      int run;
      int start;
      run = 0;
      start = 0;
      for (int i = 0; i < UNITS; i++) begin
         if (map_used[i]) begin
            run = 0;
            start = i + 1;
         end else begin
            run++;
            if (run == len) return start;
         end
      end
      return -1;
   endfunction

   function automatic void clear_tables();
      for (int i = 0; i < UNITS; i++) begin
         map_used[i] = 1'b0;
         map_byte[i] = '0;
         map_written[i] = 1'b0;
         tbl_proc[i] = '0;
         tbl_seg[i] = '0;
         tbl_lim[i] = '0;
      end
   endfunction

   function automatic sffa_pkg::rsp_type predict_rsp(sffa_pkg::req_type r);
      sffa_pkg::rsp_type o;
      int e;
      o = '{status: sffa_pkg::ST_INVALID, base_address: '0, read_data: '0};
      case (r.command)
         sffa_pkg::CMD_ALLOC: begin
            if (r.process_id == 0 || r.length == 0) o.status = sffa_pkg::ST_INVALID;
            else if (lookup_entry(r.process_id, r.segment_number) >= 0)
               o.status = sffa_pkg::ST_EXISTS;
            else begin
               e = (r.length > UNITS) ? -1 : fit_scan(r.length);
               if (e < 0) o.status = sffa_pkg::ST_NO_SPACE;
               else begin
                  for (int i = e; i < e + r.length; i++) map_used[i] = 1'b1;
                  tbl_proc[e] = r.process_id;
                  tbl_seg[e] = r.segment_number;
                  tbl_lim[e] = r.length;
                  o.status = sffa_pkg::ST_OK;
                  o.base_address = e[5:0];
               end
            end
         end
         sffa_pkg::CMD_WRITE, sffa_pkg::CMD_READ: begin
            e = lookup_entry(r.process_id, r.segment_number);
            if (r.process_id == 0) o.status = sffa_pkg::ST_INVALID;
            else if (e < 0) o.status = sffa_pkg::ST_NOT_FOUND;
            else begin
               o.base_address = e[5:0];
               if (r.offset >= tbl_lim[e] || e + r.offset >= UNITS)
                  o.status = sffa_pkg::ST_ADDR_ERR;
               else begin
                  o.status = sffa_pkg::ST_OK;
                  if (r.command == sffa_pkg::CMD_WRITE) begin
                     map_byte[e + r.offset] = r.write_data;
                     map_written[e + r.offset] = 1'b1;
                  end else o.read_data = map_byte[e + r.offset];
               end
            end
         end
         sffa_pkg::CMD_FREE_SEG: begin
            e = lookup_entry(r.process_id, r.segment_number);
            if (!any_in_use()) o.status = sffa_pkg::ST_NOTHING;
            else if (r.process_id == 0) o.status = sffa_pkg::ST_INVALID;
            else if (e < 0) o.status = sffa_pkg::ST_NOT_FOUND;
            else begin
               o.base_address = e[5:0];
               release_segment(e);
               o.status = sffa_pkg::ST_OK;
            end
         end
         sffa_pkg::CMD_FREE_PROC: begin
            if (!any_in_use()) o.status = sffa_pkg::ST_NOTHING;
            else if (r.process_id == 0) o.status = sffa_pkg::ST_INVALID;
            else begin
               o.status = sffa_pkg::ST_NOT_FOUND;
               for (int i = 0; i < UNITS; i++) begin
                  if (tbl_proc[i] == r.process_id) begin
                     release_segment(i);
                     o.status = sffa_pkg::ST_OK;
                  end
               end
            end
         end
         sffa_pkg::CMD_FREE_ALL: begin
            if (!any_in_use()) o.status = sffa_pkg::ST_NOTHING;
            else begin
               clear_tables();
               for (int i = 0; i < UNITS; i++) begin
                  map_byte[i] = sffa_pkg::BLANK_BYTE;
                  map_written[i] = 1'b1;
               end
               o.status = sffa_pkg::ST_OK;
            end
         end
         default: o.status = sffa_pkg::ST_INVALID;
      endcase
      return o;
   endfunction

   // never read a unit that was never written
   function automatic sffa_pkg::req_type make_safe(sffa_pkg::req_type r);
      int e;
      if (r.command == sffa_pkg::CMD_READ && r.process_id != 0) begin
         e = lookup_entry(r.process_id, r.segment_number);
         if (e >= 0 && r.offset < tbl_lim[e] && e + r.offset < UNITS
             && !map_written[e + r.offset]) r.command = sffa_pkg::CMD_WRITE;
      end
      return r;
   endfunction

   task automatic send_req(sffa_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r = make_safe(r);
      expected_rsp.push_back(predict_rsp(r));
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   function automatic sffa_pkg::req_type build(logic [2:0] c, logic [7:0] p, logic [7:0] s,
                                               logic [6:0] l, logic [5:0] o, logic [7:0] w);
      sffa_pkg::req_type r;
      r.command = c; r.process_id = p; r.segment_number = s;
      r.length = l; r.offset = o; r.write_data = w;
      return r;
   endfunction

   always @(posedge clock) begin
      sffa_pkg::rsp_type got;
      sffa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_data;
         if (expected_rsp.size() == 0) begin
            $display("%0t unexpected transaction %h", $time, got);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status) begin
               $display("%0t status exp %0d got %0d", $time, want.status, got.status);
               fail_count++;
            end
            if (got.base_address !== want.base_address) begin
               $display("%0t base exp %0d got %0d", $time, want.base_address,
                        got.base_address);
               fail_count++;
            end
            if (got.read_data !== want.read_data) begin
               $display("%0t data exp %h got %h", $time, want.read_data, got.read_data);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (send_done) begin
         rsp_wait = 0;
         rsp_stall <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_wait = $urandom_range(0, 15);
         rsp_stall <= (rsp_wait != 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= (rsp_wait != 0);
      end
   end

   task automatic test_special_cases();
      send_req(build(sffa_pkg::CMD_FREE_ALL, 8'd1, 8'd0, 7'd0, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_FREE_SEG, 8'd1, 8'd0, 7'd0, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_FREE_PROC, 8'd0, 8'd0, 7'd0, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_ALLOC, 8'd0, 8'd1, 7'd4, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_ALLOC, 8'd1, 8'd1, 7'd0, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_ALLOC, 8'd1, 8'd1, 7'd65, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_ALLOC, 8'd1, 8'd1, 7'd127, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_ALLOC, 8'd255, 8'd255, 7'd64, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_WRITE, 8'd255, 8'd255, 7'd0, 6'd63, 8'hFF));
      send_req(build(sffa_pkg::CMD_READ, 8'd255, 8'd255, 7'd0, 6'd63, 8'd0));
      send_req(build(sffa_pkg::CMD_ALLOC, 8'd2, 8'd0, 7'd1, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_FREE_ALL, 8'd0, 8'd0, 7'd0, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_READ, 8'd1, 8'd9, 7'd0, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_ALLOC, 8'd1, 8'd9, 7'd3, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_ALLOC, 8'd1, 8'd9, 7'd3, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_WRITE, 8'd1, 8'd9, 7'd0, 6'd3, 8'hAA));
      send_req(build(sffa_pkg::CMD_WRITE, 8'd0, 8'd9, 7'd0, 6'd0, 8'h00));
      send_req(build(sffa_pkg::CMD_READ, 8'd0, 8'd9, 7'd0, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_READ, 8'd1, 8'd9, 7'd0, 6'd2, 8'd0));
      send_req(build(sffa_pkg::CMD_FREE_SEG, 8'd0, 8'd9, 7'd0, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_FREE_SEG, 8'd1, 8'd8, 7'd0, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_FREE_PROC, 8'd7, 8'd0, 7'd0, 6'd0, 8'd0));
      send_req(build(3'd6, 8'd1, 8'd9, 7'd1, 6'd0, 8'd0));
      send_req(build(3'd7, 8'd1, 8'd9, 7'd1, 6'd0, 8'd0));
      send_req(build(sffa_pkg::CMD_FREE_PROC, 8'd1, 8'd0, 7'd0, 6'd0, 8'd0));
      drain();
   endtask

   task automatic test_random_traffic(int count);
      sffa_pkg::req_type r;
      logic [63:0]       raw;
      int                pick;
      for (int n = 0; n < count; n++) begin
         raw = {$urandom(), $urandom()};
         r = raw[$bits(sffa_pkg::req_type)-1:0];
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            r.process_id = 8'($urandom_range(1, 4));
            r.segment_number = 8'($urandom_range(0, 3));
            if (pick < 55) r.offset = 6'($urandom_range(0, 7));
            if (pick < 25) begin
               r.command = sffa_pkg::CMD_ALLOC;
               r.length = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                       : 7'($urandom_range(1, 10));
            end else if (pick < 45) r.command = sffa_pkg::CMD_WRITE;
            else if (pick < 65) r.command = sffa_pkg::CMD_READ;
            else if (pick < 77) r.command = sffa_pkg::CMD_FREE_SEG;
            else if (pick < 82) r.command = sffa_pkg::CMD_FREE_PROC;
            else r.command = ($urandom_range(0, 3) == 0) ? sffa_pkg::CMD_FREE_ALL
                                                         : sffa_pkg::CMD_ALLOC;
         end
         send_req(r);
         if (n == count / 2) drain();
      end
   endtask

   initial begin
      clear_tables();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_random_traffic(2000);
      send_done = 1'b1;
      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
